[rtl/core/track_insertion_sorter_macros.svh]
// Assertion helpers for the track sorter.
`ifndef TRACK_INSERTION_SORTER_MACROS_SVH
`define TRACK_INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TIS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TIS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tis_pkg.sv]
package tis_pkg;

    localparam int DEPTH        = 64;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int MIN_W        = 8;
    localparam int SEC_W        = 6;
    localparam int TAG_W        = 16;
    localparam int KEY_W        = 14;
    localparam int SECS_PER_MIN = 60;

    // Stored entry, minutes in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SEC_W-1:0] seconds;
        logic [MIN_W-1:0] minutes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sort key: total seconds
    function automatic logic [KEY_W-1:0] key_of(entry_t e);
        logic [KEY_W-1:0] k;
        k = KEY_W'(e.minutes) * KEY_W'(SECS_PER_MIN) + KEY_W'(e.seconds);
        return k;
    endfunction

endpackage

[rtl/core/tis_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module tis_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/track_insertion_sorter.sv]
// Channel | Dir | Fields
// s_      | in  | tdata: minutes, seconds, tag; tlast: last item of the set
// m_      | out | tdata: minutes, seconds, tag; tlast: last entry; tuser: overflow
//
// Insertion moves up each stored entry, from the top down, whose key is not below
// the new one, then writes it into the gap; an empty store takes it at once, a full
// one drops it. Emission gives one word per cycle while m_tready stays high.
// Reset (aresetn low, synchronous) empties the store; RAM contents are kept.
// Input is taken only between items; a stalled output word holds in the RAM
// read register.
module track_insertion_sorter
    import tis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] len_minutes, [13:8] len_seconds, [29:14] record_tag
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_minutes, [13:8] out_seconds, [29:14] out_tag
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflowed
);

`include "track_insertion_sorter_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEARCH   = 5'b00010,
        ST_PLACE    = 5'b00100,
        ST_EMIT_RD  = 5'b01000,
        ST_EMIT_OUT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    entry_t              item_reg, item_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                last_reg, last_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;
    entry_t              s_entry;
    logic                s_fire;
    logic                m_fire;

    assign s_entry  = entry_t'(s_tdata[ENTRY_W-1:0]);
    assign rd_entry = entry_t'(ram_rdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT_OUT);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = {{(32 - ENTRY_W){1'b0}}, ram_rdata};
    assign m_tlast  = ((CNT_W'(addr_reg) + CNT_W'(1)) == fill_reg);
    assign m_tuser  = ovf_reg;

    tis_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk the store from the top down, moving entries not smaller up one slot, then emit
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        addr_next  = addr_reg;
        item_next  = item_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = item_reg;
        ram_re     = 1'b0;
        ram_raddr  = addr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    item_next = s_entry;
                    key_next  = key_of(s_entry);
                    last_next = s_tlast;
                    if (fill_reg == CNT_W'(DEPTH)) begin
                        // Store full: drop the word
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_EMIT_RD : ST_IDLE;
                    end else if (fill_reg == '0) begin
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = s_entry;
                        fill_next  = CNT_W'(1);
                        state_next = s_tlast ? ST_EMIT_RD : ST_IDLE;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = ADDR_W'(fill_reg - CNT_W'(1));
                        addr_next  = ADDR_W'(fill_reg - CNT_W'(1));
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (key_reg <= key_of(rd_entry)) begin
                    // Move the stored entry up and look one lower
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg + ADDR_W'(1);
                    ram_wdata = rd_entry;
                    if (addr_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_reg - ADDR_W'(1);
                        addr_next = addr_reg - ADDR_W'(1);
                    end
                end else begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = item_reg;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                addr_next  = '0;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                // Advance to the next entry on each taken word
                if (m_fire) begin
                    if (m_tlast) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_reg + ADDR_W'(1);
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Item and walk pointer
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        item_reg <= item_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

    `TIS_ASSERT_IMP(a_no_overlap, aclk, aresetn, 1'b1, !(s_tready && m_tvalid),
        "input and output channels active together")
    `TIS_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(DEPTH),
        "fill count above depth")
    `TIS_ASSERT_NXT(a_clear_after_run, aclk, aresetn, m_fire && m_tlast,
        (fill_reg == '0) && !ovf_reg, "store not cleared after last word")
    `TIS_ASSERT_NXT(a_drop_flags, aclk, aresetn, s_fire && (fill_reg == CNT_W'(DEPTH)),
        ovf_reg, "dropped word did not set overflow")

endmodule

[test/tb_track_insertion_sorter.sv]
module tb_track_insertion_sorter;
    import tis_pkg::*;

    localparam int CLK_HI     = 2;
    localparam int CLK_LO     = 2;
    localparam int RST_CYCLES = 5;
    localparam int MAX_CYCLES = 400000;
    // insertion walks up to DEPTH entries, emission takes one more word per entry
    localparam int TAIL_CYCLES = 2 * DEPTH + 16;

    // one emitted word as predicted
    typedef struct {
        entry_t ent;
        logic   last;
        logic   ovf;
    } track_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predicted store contents
    entry_t      shelf [DEPTH];
    int unsigned shelf_cnt     = 0;
    bit          shelf_dropped = 1'b0;

    track_word_t playlist_q [$];

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned fail_cnt      = 0;
    int unsigned words_checked = 0;
    int unsigned items_sent    = 0;
    int unsigned sets_sent     = 0;
    int unsigned ovf_sets      = 0;
    int unsigned cycle_cnt     = 0;

    track_insertion_sorter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #CLK_HI aclk = 1'b1;
        #CLK_LO aclk = 1'b0;
    end

    // total length in seconds, seconds above 59 counted as given
    function automatic int unsigned total_secs(entry_t e);
        return int'(e.minutes) * SECS_PER_MIN + int'(e.seconds);
    endfunction

    // insert one track into the predicted store; emit and clear on the last one
    function automatic void insert_track(entry_t e, bit last);
        int unsigned pos;
        track_word_t w;
        if (shelf_cnt < DEPTH) begin
            pos = shelf_cnt;
            for (int unsigned i = 0; i < shelf_cnt; i++) begin
                if (total_secs(e) <= total_secs(shelf[i])) begin
                    pos = i;
                    break;
                end
            end
            for (int unsigned i = shelf_cnt; i > pos; i--)
                shelf[i] = shelf[i-1];
            shelf[pos] = e;
            shelf_cnt++;
        end else begin
            shelf_dropped = 1'b1;
        end
        if (last) begin
            if (shelf_dropped)
                ovf_sets++;
            for (int unsigned k = 0; k < shelf_cnt; k++) begin
                w.ent  = shelf[k];
                w.last = (k + 1 == shelf_cnt);
                w.ovf  = shelf_dropped;
                playlist_q = {playlist_q, w};
            end
            shelf_cnt     = 0;
            shelf_dropped = 1'b0;
            sets_sent++;
        end
    endfunction

    function automatic entry_t make_track(int unsigned mins, int unsigned secs,
                                          int unsigned tag);
        entry_t e;
        e.minutes = mins[MIN_W-1:0];
        e.seconds = secs[SEC_W-1:0];
        e.tag     = tag[TAG_W-1:0];
        return e;
    endfunction

    // half full range, half clustered keys so equal totals show up often
    function automatic entry_t rand_track();
        entry_t e;
        e.tag = TAG_W'($urandom);
        if ($urandom_range(1) == 0) begin
            e.minutes = MIN_W'($urandom_range(255));
            e.seconds = SEC_W'($urandom_range(63));
        end else begin
            e.minutes = MIN_W'($urandom_range(2));
            case ($urandom_range(3))
                0: e.seconds = '0;
                1: e.seconds = SEC_W'(59);
                2: e.seconds = SEC_W'(60);
                default: e.seconds = SEC_W'($urandom_range(63));
            endcase
        end
        return e;
    endfunction

    // present one word and hold it until accepted
    task automatic send_track(entry_t e, bit last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 32'(e);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        insert_track(e, last);
    endtask

    // drop valid and wait for a clock edge
    task automatic release_bus();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_set(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_track(rand_track(), i + 1 == len);
    endtask

    // extremes, equal keys, ascending and descending order
    task automatic test_directed();
        send_track(make_track(255, 63, 16'hFFFF), 1'b1);

        send_track(make_track(1, 0, 16'h1111), 1'b0);
        send_track(make_track(0, 60, 16'h2222), 1'b0);
        send_track(make_track(0, 59, 16'h3333), 1'b0);
        send_track(make_track(0, 61, 16'h4444), 1'b0);
        send_track(make_track(1, 0, 16'h5555), 1'b1);

        send_track(make_track(0, 0, 16'h0000), 1'b0);
        send_track(make_track(0, 1, 16'h0001), 1'b0);
        send_track(make_track(2, 30, 16'hAAAA), 1'b0);
        send_track(make_track(200, 0, 16'h5555), 1'b0);
        send_track(make_track(255, 59, 16'h8000), 1'b1);

        send_track(make_track(255, 63, 16'h7FFF), 1'b0);
        send_track(make_track(128, 32, 16'h00FF), 1'b0);
        send_track(make_track(64, 16, 16'hFF00), 1'b0);
        send_track(make_track(0, 0, 16'hFFFF), 1'b1);
    endtask

    // mostly short sets, now and then a longer one
    task automatic test_random_sets(int unsigned n_items);
        int unsigned done;
        int unsigned len;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(40, 20);
            else
                len = $urandom_range(8, 1);
            // keep the item count of this phase
            if (len > n_items - done)
                len = n_items - done;
            send_set(len);
            done += len;
        end
    endtask

    // fill the store, then push a few more so they drop, the last one too
    task automatic test_store_full();
        send_set(DEPTH + $urandom_range(4, 1));
    endtask

    // after each set hold off until the sorted run is fully out
    task automatic test_pause_until_drained();
        for (int unsigned s = 0; s < 3; s++) begin
            send_set($urandom_range(6, 2));
            release_bus();
            while (playlist_q.size() != 0) @(posedge aclk);
        end
    endtask

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        track_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (playlist_q.size() == 0) begin
                $error("unexpected word: tdata %h tlast %b tuser %b",
                       m_tdata, m_tlast, m_tuser);
                fail_cnt++;
            end else begin
                w = playlist_q.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== w.ent.minutes) begin
                    $error("out_minutes: expected %0d, actual %0d",
                           w.ent.minutes, m_tdata[7:0]);
                    fail_cnt++;
                end
                if (m_tdata[13:8] !== w.ent.seconds) begin
                    $error("out_seconds: expected %0d, actual %0d",
                           w.ent.seconds, m_tdata[13:8]);
                    fail_cnt++;
                end
                if (m_tdata[29:14] !== w.ent.tag) begin
                    $error("out_tag: expected %h, actual %h", w.ent.tag, m_tdata[29:14]);
                    fail_cnt++;
                end
                if (m_tlast !== w.last) begin
                    $error("out_last: expected %b, actual %b", w.last, m_tlast);
                    fail_cnt++;
                end
                if (m_tuser !== w.ovf) begin
                    $error("overflowed: expected %b, actual %b", w.ovf, m_tuser);
                    fail_cnt++;
                end
            end
        end
        m_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
    end

    // end the run if it hangs
    initial begin
        while (cycle_cnt < MAX_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb_track_insertion_sorter: FAIL");
        $finish;
    end

    initial begin
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no idling
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        test_directed();
        test_random_sets(15);

        // sender idles
        src_idle_pct  = 69;
        snk_stall_pct = 0;
        test_random_sets(15);

        // receiver stalls
        src_idle_pct  = 0;
        snk_stall_pct = 69;
        test_random_sets(15);
        test_store_full();

        // both sides idle
        src_idle_pct  = 37;
        snk_stall_pct = 37;
        test_random_sets(15);
        test_pause_until_drained();

        // drain and watch for stray words
        release_bus();
        while (playlist_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d tracks in %0d sets (%0d with dropped tracks), checked %0d words",
                 items_sent, sets_sent, ovf_sets, words_checked);
        $display("Covered key extremes, equal keys, a full store and four idle patterns");
        if (fail_cnt == 0)
            $display("tb_track_insertion_sorter: PASS");
        else
            $display("tb_track_insertion_sorter: FAIL");
        $finish;
    end

endmodule

[track_insertion_sorter.f]
+incdir+rtl/core
rtl/core/tis_pkg.sv
rtl/core/tis_ram.sv
rtl/core/track_insertion_sorter.sv
test/tb_track_insertion_sorter.sv
